// ----- sv/jse_pkg.sv -----
// Shared types, constants and helper functions for the JSON string escaper.
// Used by jse_front, jse_queue, jse_back and json_string_escaper_unit.
package jse_pkg;

   localparam int QUEUE_DEPTH = 2;

   localparam logic [15:0] QUOTE_UNIT  = 16'h0022;
   localparam logic [15:0] BSLASH_UNIT = 16'h005c;
   localparam logic [15:0] COLON_UNIT  = 16'h003a;
   localparam logic [15:0] DEL_UNIT    = 16'h007f;
   localparam logic [15:0] SPACE_UNIT  = 16'h0020;
   localparam logic [15:0] U_UNIT      = 16'h0075;
   localparam logic [15:0] ZERO_UNIT   = 16'h0030;

   localparam logic [1:0] KIND_NONE  = 2'd0;
   localparam logic [1:0] KIND_PLAIN = 2'd1;
   localparam logic [1:0] KIND_SHORT = 2'd2;
   localparam logic [1:0] KIND_LONG  = 2'd3;

   typedef struct packed {
      logic [15:0] code_unit;
      logic        has_unit;
      logic        first_of_string;
      logic        last_of_string;
      logic        add_colon;
   } req_payload_type;

   typedef struct packed {
      logic [15:0] out_unit;
      logic        run_end;
   } rsp_payload_type;

   typedef struct packed {
      logic [15:0] code_unit;
      logic [1:0]  kind;
      logic        first;
      logic        last;
      logic        colon;
      logic [3:0]  count;
   } entry_type;

   typedef struct packed {
      logic      push;
      entry_type entry;
   } push_type;

   function automatic logic [15:0] short_second(input logic [15:0] u);
      logic [15:0] s;
      s = 16'h0000;
      case (u)
         16'h0008: s = 16'h0062;
         16'h0009: s = 16'h0074;
         16'h000a: s = 16'h006e;
         16'h000c: s = 16'h0066;
         16'h000d: s = 16'h0072;
         BSLASH_UNIT: s = BSLASH_UNIT;
         QUOTE_UNIT: s = QUOTE_UNIT;
         default: s = 16'h0000;
      endcase
      return s;
   endfunction

   function automatic logic [15:0] hex_char(input logic [3:0] n);
      logic [15:0] c;
      if (n < 4'd10) begin
         c = ZERO_UNIT + {12'd0, n};
      end else begin
         c = 16'h0057 + {12'd0, n};
      end
      return c;
   endfunction

   function automatic logic [2:0] esc_len(input logic [1:0] kind);
      logic [2:0] l;
      case (kind)
         KIND_PLAIN: l = 3'd1;
         KIND_SHORT: l = 3'd2;
         KIND_LONG: l = 3'd6;
         default: l = 3'd0;
      endcase
      return l;
   endfunction

endpackage

// ----- sv/jse_front.sv -----
// Front end: accepts input items, classifies the escape and counts output units.
// Depends on jse_pkg; feeds jse_queue.
module jse_front (
   input  logic                     req_valid,
   input  jse_pkg::req_payload_type req_data,
   input  logic                     queue_full,
   output logic                     req_stall,
   output jse_pkg::push_type        push_out
);

   logic [1:0] kind;
   logic [3:0] count;

   always_comb begin
      if (!req_data.has_unit) begin
         kind = jse_pkg::KIND_NONE;
      end else if (jse_pkg::short_second(req_data.code_unit) != 16'h0000) begin
         kind = jse_pkg::KIND_SHORT;
      end else if (req_data.code_unit < jse_pkg::SPACE_UNIT ||
                   req_data.code_unit == jse_pkg::DEL_UNIT) begin
         kind = jse_pkg::KIND_LONG;
      end else begin
         kind = jse_pkg::KIND_PLAIN;
      end
   end

   assign count = {3'd0, req_data.first_of_string} + {1'b0, jse_pkg::esc_len(kind)}
                + {3'd0, req_data.last_of_string}
                + {3'd0, req_data.last_of_string & req_data.add_colon};

   assign req_stall = queue_full;

   always_comb begin
      push_out.push            = req_valid && !queue_full && count != 4'd0;
      push_out.entry.code_unit = req_data.code_unit;
      push_out.entry.kind      = kind;
      push_out.entry.first     = req_data.first_of_string;
      push_out.entry.last      = req_data.last_of_string;
      push_out.entry.colon     = req_data.add_colon;
      push_out.entry.count     = count;
   end

endmodule

// ----- sv/jse_queue.sv -----
// Short queue of classified items between front and back ends.
// Depends on jse_pkg.
module jse_queue #(
   parameter int DEPTH = jse_pkg::QUEUE_DEPTH
) (
   input  logic                clock,
   input  logic                reset,
   input  jse_pkg::push_type   push_in,
   input  logic                pop,
   output logic                full,
   output logic                not_empty,
   output jse_pkg::entry_type  head
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
   localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

   jse_pkg::entry_type slot_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;

   assign full      = count_ff == FULL_COUNT;
   assign not_empty = count_ff != '0;
   assign head      = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_in.push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push_in.push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push_in.push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_in.push) begin
         slot_ff[wr_ptr_ff] <= push_in.entry;
      end
   end

endmodule

// ----- sv/jse_back.sv -----
// Back end: steps through each queued item's output units into an output register.
// Depends on jse_pkg; reads the head of jse_queue.
module jse_back (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     head_valid,
   input  jse_pkg::entry_type       head,
   output logic                     pop,
   output logic                     rsp_valid,
   output jse_pkg::rsp_payload_type rsp_data,
   input  logic                     rsp_stall
);

   logic [3:0] pos_ff, pos_in;
   logic       valid_ff, valid_in;
   jse_pkg::rsp_payload_type data_ff, data_in;

   logic       emit;
   logic       done;
   logic [3:0] idx;
   logic [3:0] elen;
   logic [15:0] unit;

   assign emit = head_valid && (!valid_ff || !rsp_stall);
   assign done = pos_ff == head.count - 4'd1;
   assign pop  = emit && done;
   assign idx  = pos_ff - {3'd0, head.first};
   assign elen = {1'b0, jse_pkg::esc_len(head.kind)};

   always_comb begin
      if (head.first && pos_ff == 4'd0) begin
         unit = jse_pkg::QUOTE_UNIT;
      end else if (idx < elen) begin
         case (head.kind)
            jse_pkg::KIND_SHORT: begin
               unit = (idx == 4'd0) ? jse_pkg::BSLASH_UNIT
                                    : jse_pkg::short_second(head.code_unit);
            end
            jse_pkg::KIND_LONG: begin
               case (idx[2:0])
                  3'd0: unit = jse_pkg::BSLASH_UNIT;
                  3'd1: unit = jse_pkg::U_UNIT;
                  3'd2, 3'd3: unit = jse_pkg::ZERO_UNIT;
                  3'd4: unit = jse_pkg::hex_char(head.code_unit[7:4]);
                  default: unit = jse_pkg::hex_char(head.code_unit[3:0]);
               endcase
            end
            default: unit = head.code_unit;
         endcase
      end else if (idx == elen) begin
         unit = jse_pkg::QUOTE_UNIT;
      end else begin
         unit = jse_pkg::COLON_UNIT;
      end
   end

   always_comb begin
      pos_in   = pos_ff;
      valid_in = valid_ff;
      data_in  = data_ff;
      if (emit) begin
         pos_in           = done ? 4'd0 : pos_ff + 4'd1;
         valid_in         = 1'b1;
         data_in.out_unit = unit;
         data_in.run_end  = done;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         pos_ff   <= pos_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

// ----- sv/json_string_escaper_unit.sv -----
// JSON string escaper top level: front classifier, item queue and unit emitter.
// Depends on jse_pkg, jse_front, jse_queue and jse_back.
//
// Takes a UTF-16 string one code unit per item and emits its JSON-quoted form,
// one output unit per cycle while rsp_stall is low: opening quote, the unit or
// its escape (1, 2 or 6 units), closing quote and optional colon; run_end marks
// the last unit of an item. An item produces 1 to 9 units, one at a time through
// the single output register of the emitter; an item that produces nothing is
// still accepted and is dropped at the front. Plain units flow at one per cycle
// while rsp_stall is low. Each unit passes through the emitter's output register.
// The queue of QUEUE_DEPTH classified items lets input be taken while an escape
// sequence is still being emitted.
module json_string_escaper_unit #(
   parameter int QUEUE_DEPTH = jse_pkg::QUEUE_DEPTH
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  jse_pkg::req_payload_type req_data,
   output logic                     req_stall,
   output logic                     rsp_valid,
   output jse_pkg::rsp_payload_type rsp_data,
   input  logic                     rsp_stall
);

   jse_pkg::push_type  push;
   jse_pkg::entry_type head;
   logic               full;
   logic               not_empty;
   logic               pop;

   jse_front u_front (
      .req_valid  (req_valid),
      .req_data   (req_data),
      .queue_full (full),
      .req_stall  (req_stall),
      .push_out   (push)
   );

   jse_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push_in   (push),
      .pop       (pop),
      .full      (full),
      .not_empty (not_empty),
      .head      (head)
   );

   jse_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (not_empty),
      .head       (head),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_data   (rsp_data),
      .rsp_stall  (rsp_stall)
   );

endmodule

// ----- tb/sv/tb_escape_pkg.sv -----
// Scoreboard for the JSON string escaper testbench: predicts escaped units per item
// and checks the result stream against them. Depends on jse_pkg.
package tb_escape_pkg;

   localparam logic [15:0] LETTER_A = 16'h0061;
   localparam logic [15:0] LETTER_B = 16'h0062;
   localparam logic [15:0] LETTER_F = 16'h0066;
   localparam logic [15:0] LETTER_N = 16'h006e;
   localparam logic [15:0] LETTER_R = 16'h0072;
   localparam logic [15:0] LETTER_T = 16'h0074;
   localparam logic [15:0] LETTER_U = 16'h0075;
   localparam logic [15:0] DIGIT_0  = 16'h0030;

   localparam logic [15:0] CTRL_BS  = 16'h0008;
   localparam logic [15:0] CTRL_TAB = 16'h0009;
   localparam logic [15:0] CTRL_LF  = 16'h000a;
   localparam logic [15:0] CTRL_FF  = 16'h000c;
   localparam logic [15:0] CTRL_CR  = 16'h000d;

   class escape_checker;
      jse_pkg::rsp_payload_type expected_units[$];
      int error_count;

      function new();
         error_count = 0;
      endfunction

      function void report(string what);
         $display("[%0t] mismatch: %s", $time, what);
         error_count++;
      endfunction

      function logic [15:0] hex_digit(logic [3:0] n);
         if (n < 4'd10) begin
            return DIGIT_0 + {12'd0, n};
         end
         return LETTER_A + {12'd0, n} - 16'd10;
      endfunction

      function void note_item(jse_pkg::req_payload_type item);
         logic [15:0] units[$];
         logic [15:0] c;
         logic [15:0] second;
         jse_pkg::rsp_payload_type r;
         c = item.code_unit;
         second = 16'h0000;
         if (item.first_of_string) begin
            units.push_back(jse_pkg::QUOTE_UNIT);
         end
         if (item.has_unit) begin
            case (c)
               CTRL_BS: second = LETTER_B;
               CTRL_TAB: second = LETTER_T;
               CTRL_LF: second = LETTER_N;
               CTRL_FF: second = LETTER_F;
               CTRL_CR: second = LETTER_R;
               jse_pkg::BSLASH_UNIT: second = jse_pkg::BSLASH_UNIT;
               jse_pkg::QUOTE_UNIT: second = jse_pkg::QUOTE_UNIT;
               default: second = 16'h0000;
            endcase
            if (second != 16'h0000) begin
               units.push_back(jse_pkg::BSLASH_UNIT);
               units.push_back(second);
            end else if (c < jse_pkg::SPACE_UNIT || c == jse_pkg::DEL_UNIT) begin
               units.push_back(jse_pkg::BSLASH_UNIT);
               units.push_back(LETTER_U);
               units.push_back(DIGIT_0);
               units.push_back(DIGIT_0);
               units.push_back(hex_digit(c[7:4]));
               units.push_back(hex_digit(c[3:0]));
            end else begin
               units.push_back(c);
            end
         end
         if (item.last_of_string) begin
            units.push_back(jse_pkg::QUOTE_UNIT);
            if (item.add_colon) begin
               units.push_back(jse_pkg::COLON_UNIT);
            end
         end
         foreach (units[i]) begin
            r.out_unit = units[i];
            r.run_end = (i == units.size() - 1);
            expected_units.push_back(r);
         end
      endfunction

      function void check_unit(jse_pkg::rsp_payload_type got);
         jse_pkg::rsp_payload_type want;
         if (expected_units.size() == 0) begin
            report($sformatf("unit %h with nothing expected", got.out_unit));
            return;
         end
         want = expected_units.pop_front();
         if (got.out_unit !== want.out_unit) begin
            report($sformatf("out_unit %h, want %h", got.out_unit, want.out_unit));
         end
         if (got.run_end !== want.run_end) begin
            report($sformatf("run_end %b, want %b on unit %h",
                             got.run_end, want.run_end, want.out_unit));
         end
      endfunction

      function int pending();
         return expected_units.size();
      endfunction

      function void final_check();
         if (expected_units.size() != 0) begin
            report($sformatf("%0d expected units never arrived", expected_units.size()));
         end
      endfunction
   endclass

endpackage

// ----- tb/sv/tb_top.sv -----
// Top-level testbench for json_string_escaper_unit: directed and random strings
// under several idle/stall mixes. Depends on jse_pkg and tb_escape_pkg.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 200000;
   localparam int HOLD_CYCLES = 300;
   localparam int DRAIN_SLACK = 8;
   localparam int STRINGS_PER_PHASE = 12;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   jse_pkg::req_payload_type req_data = '0;
   logic req_stall;
   logic rsp_valid;
   jse_pkg::rsp_payload_type rsp_data;
   logic rsp_stall = 1'b0;

   tb_escape_pkg::escape_checker sb = new();
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int cycle_count = 0;
   int hold_left = 0;
   logic hold_request = 1'b0;
   int send_pct_of[4] = '{0, 69, 0, 34};
   int recv_pct_of[4] = '{0, 0, 69, 34};

   json_string_escaper_unit uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_data(req_data),
      .req_stall(req_stall),
      .rsp_valid(rsp_valid),
      .rsp_data(rsp_data),
      .rsp_stall(rsp_stall)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            sb.note_item(req_data);
         end
         if (rsp_valid && !rsp_stall) begin
            sb.check_unit(rsp_data);
         end
      end
   end

   initial begin
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else begin
            rsp_stall <= ($urandom_range(99) < recv_idle_pct);
         end
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Regression FAIL");
      $finish;
   end

   function automatic jse_pkg::req_payload_type mk(logic [15:0] unit, logic has,
                                                   logic first, logic last,
                                                   logic colon);
      jse_pkg::req_payload_type item;
      item.code_unit = unit;
      item.has_unit = has;
      item.first_of_string = first;
      item.last_of_string = last;
      item.add_colon = colon;
      return item;
   endfunction

   function automatic logic [15:0] pick_unit();
      logic [15:0] u;
      case ($urandom_range(5))
         0: u = 16'($urandom_range(16'h001f));
         1: begin
            case ($urandom_range(2))
               0: u = jse_pkg::QUOTE_UNIT;
               1: u = jse_pkg::BSLASH_UNIT;
               default: u = jse_pkg::DEL_UNIT;
            endcase
         end
         2: u = 16'($urandom_range(16'h007e, 16'h0020));
         3: u = 16'($urandom_range(16'hffff));
         4: u = 16'($urandom_range(16'hdfff, 16'hd800));
         default: u = 16'($urandom_range(16'h007e, 16'h0020));
      endcase
      return u;
   endfunction

   task automatic send_item(input jse_pkg::req_payload_type item);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      repeat (2) @(posedge clock);
      while (sb.pending() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_SLACK) @(posedge clock);
   endtask

   task automatic send_random_string();
      int len;
      logic [19:0] noise;
      jse_pkg::req_payload_type item;
      if ($urandom_range(99) < 12) begin
         noise = 20'($urandom);
         item = noise;
         send_item(item);
      end else begin
         len = $urandom_range(6);
         if (len == 0) begin
            send_item(mk(pick_unit(), 1'b0, 1'b1, 1'b1, 1'($urandom_range(1))));
         end else begin
            for (int i = 0; i < len; i++) begin
               send_item(mk(pick_unit(), 1'b1, i == 0, i == len - 1,
                            1'($urandom_range(1))));
            end
         end
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_item(mk(16'h0000, 1'b0, 1'b1, 1'b1, 1'b1));
      send_item(mk(16'hffff, 1'b0, 1'b1, 1'b1, 1'b0));
      send_item(mk(16'hffff, 1'b0, 1'b0, 1'b0, 1'b1));
      send_item(mk(16'h0000, 1'b1, 1'b1, 1'b0, 1'b0));
      send_item(mk(tb_escape_pkg::CTRL_BS, 1'b1, 1'b0, 1'b0, 1'b0));
      send_item(mk(tb_escape_pkg::CTRL_TAB, 1'b1, 1'b0, 1'b0, 1'b0));
      send_item(mk(tb_escape_pkg::CTRL_LF, 1'b1, 1'b0, 1'b0, 1'b0));
      send_item(mk(tb_escape_pkg::CTRL_FF, 1'b1, 1'b0, 1'b0, 1'b0));
      send_item(mk(tb_escape_pkg::CTRL_CR, 1'b1, 1'b0, 1'b0, 1'b0));
      send_item(mk(jse_pkg::BSLASH_UNIT, 1'b1, 1'b0, 1'b0, 1'b0));
      send_item(mk(jse_pkg::QUOTE_UNIT, 1'b1, 1'b0, 1'b0, 1'b0));
      send_item(mk(jse_pkg::DEL_UNIT, 1'b1, 1'b0, 1'b0, 1'b0));
      send_item(mk(16'h001f, 1'b1, 1'b0, 1'b0, 1'b0));
      send_item(mk(16'h000b, 1'b1, 1'b0, 1'b0, 1'b0));
      send_item(mk(jse_pkg::SPACE_UNIT, 1'b1, 1'b0, 1'b0, 1'b0));
      send_item(mk(16'hffff, 1'b1, 1'b0, 1'b0, 1'b0));
      send_item(mk(16'hd800, 1'b1, 1'b0, 1'b0, 1'b0));
      send_item(mk(16'h0080, 1'b1, 1'b0, 1'b1, 1'b1));
      send_item(mk(16'h0010, 1'b1, 1'b1, 1'b1, 1'b1));
      send_item(mk(16'h0041, 1'b1, 1'b1, 1'b1, 1'b0));
      send_item(mk(16'h0041, 1'b1, 1'b0, 1'b0, 1'b1));
      send_item(mk(16'h0000, 1'b0, 1'b1, 1'b0, 1'b0));
      send_item(mk(16'h0000, 1'b0, 1'b0, 1'b1, 1'b1));
      req_valid <= 1'b0;
      wait_drained();

      for (int p = 0; p < 4; p++) begin
         send_idle_pct = send_pct_of[p];
         recv_idle_pct = recv_pct_of[p];
         if (p == 0) begin
            hold_request = 1'b1;
         end
         for (int s = 0; s < STRINGS_PER_PHASE; s++) begin
            send_random_string();
         end
         req_valid <= 1'b0;
         wait_drained();
      end

      sb.final_check();
      if (sb.error_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
